// ----- src/jad_pkg.sv -----
// ----------------------------------------------------------------------------
// jad_pkg: joystick average direction shared definitions
// Widths, register indexes, direction codes, controller states and the
// request and response types of the iterative divider.
// ----------------------------------------------------------------------------
`default_nettype none

package jad_pkg;

  localparam int WINDOW      = 10;
  localparam int SAMPLE_BITS = 12;

  localparam int IN_BITS   = 12;
  localparam int OUT_BITS  = 12;
  localparam int CFG_BITS  = 12;
  localparam int DIR_BITS  = 2;
  localparam int CFG_IDX_W = 2;

  localparam int SLOT_W = $clog2(WINDOW);
  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int SUM_W  = $clog2(WINDOW * ((1 << SAMPLE_BITS) - 1) + 1);
  localparam int CMP_W  = (SUM_W > CFG_BITS + 1) ? SUM_W : CFG_BITS + 1;
  localparam int MEM_W  = 2 * SAMPLE_BITS;

  localparam int DIV_STEPS  = 4;
  localparam int DIV_ROUNDS = (SUM_W + DIV_STEPS - 1) / DIV_STEPS;
  localparam int DIV_QW     = DIV_ROUNDS * DIV_STEPS;
  localparam int RND_W      = $clog2(DIV_ROUNDS + 1);

  localparam logic [OUT_BITS-1:0] OUT_MAX = 12'd4095;

  localparam logic [CFG_BITS-1:0] CENTER_RESET = 12'd2047;
  localparam logic [CFG_BITS-1:0] MARGIN_RESET = 12'd300;

  localparam logic [CFG_IDX_W-1:0] REG_CENTER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MARGIN = 2'd1;

  typedef enum logic [DIR_BITS-1:0] {
    DIR_CENTER = 2'd0,
    DIR_LOW    = 2'd1,
    DIR_HIGH   = 2'd2
  } dir_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_DIV,
    ST_HOLD
  } state_t;

  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] dividend;
    logic [CNT_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [SUM_W-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

// ----- src/jad_in_if.sv -----
// ----------------------------------------------------------------------------
// jad_in_if: sample input channel
// Valid/ready channel that carries one pair of joystick samples.
// ----------------------------------------------------------------------------
`default_nettype none

interface jad_in_if;
  logic                         valid;
  logic                         ready;
  logic [jad_pkg::IN_BITS-1:0]  sample_x;
  logic [jad_pkg::IN_BITS-1:0]  sample_y;

  modport source (output valid, output sample_x, output sample_y, input ready);
  modport sink   (input valid, input sample_x, input sample_y, output ready);
endinterface

`default_nettype wire

// ----- src/jad_out_if.sv -----
// ----------------------------------------------------------------------------
// jad_out_if: result channel
// Valid/ready channel that carries both means and both direction classes.
// ----------------------------------------------------------------------------
`default_nettype none

interface jad_out_if;
  logic                          valid;
  logic                          ready;
  logic [jad_pkg::OUT_BITS-1:0]  mean_x;
  logic [jad_pkg::OUT_BITS-1:0]  mean_y;
  logic [jad_pkg::DIR_BITS-1:0]  dir_x;
  logic [jad_pkg::DIR_BITS-1:0]  dir_y;

  modport source (output valid, output mean_x, output mean_y, output dir_x, output dir_y,
                  input ready);
  modport sink   (input valid, input mean_x, input mean_y, input dir_x, input dir_y,
                  output ready);
endinterface

`default_nettype wire

// ----- src/jad_cfg_if.sv -----
// ----------------------------------------------------------------------------
// jad_cfg_if: configuration write channel
// Valid/ready channel that carries a register index and its write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface jad_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [jad_pkg::CFG_IDX_W-1:0]  index;
  logic [jad_pkg::CFG_BITS-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- src/jad_ring_mem.sv -----
// ----------------------------------------------------------------------------
// jad_ring_mem: sample ring memory
// One write port and one read port with registered read data; each entry
// holds the horizontal and vertical sample of one transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module jad_ring_mem (
  input  wire logic                        clk,
  input  wire logic                        we,
  input  wire logic [jad_pkg::SLOT_W-1:0]  waddr,
  input  wire logic [jad_pkg::MEM_W-1:0]   wdata,
  input  wire logic                        re,
  input  wire logic [jad_pkg::SLOT_W-1:0]  raddr,
  output      logic [jad_pkg::MEM_W-1:0]   rdata
);

  logic [jad_pkg::MEM_W-1:0] mem [jad_pkg::WINDOW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- src/jad_divider.sv -----
// ----------------------------------------------------------------------------
// jad_divider: iterative restoring divider
// Divides a running sum by the sample count, several quotient bits per
// cycle; the quotient holds until the next start.
// ----------------------------------------------------------------------------
`default_nettype none

module jad_divider (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire jad_pkg::div_req_t req,
  output      jad_pkg::div_rsp_t rsp
);

  logic [jad_pkg::CNT_W:0]        rem_r, rem_nxt;
  logic [jad_pkg::DIV_QW-1:0]     quo_r, quo_nxt;
  logic [jad_pkg::CNT_W-1:0]      dvs_r;
  logic [jad_pkg::RND_W-1:0]      rnd_r;
  logic                           done_r;
  logic                           busy;

  assign busy = (rnd_r != '0);

  always_comb begin
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    for (int i = 0; i < jad_pkg::DIV_STEPS; i++) begin
      rem_nxt = {rem_nxt[jad_pkg::CNT_W-1:0], quo_nxt[jad_pkg::DIV_QW-1]};
      quo_nxt = {quo_nxt[jad_pkg::DIV_QW-2:0], 1'b0};
      if (rem_nxt >= {1'b0, dvs_r}) begin
        rem_nxt    = rem_nxt - {1'b0, dvs_r};
        quo_nxt[0] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rnd_r  <= '0;
      done_r <= 1'b0;
    end else if (req.start) begin
      rnd_r  <= jad_pkg::RND_W'(jad_pkg::DIV_ROUNDS);
      done_r <= 1'b0;
    end else begin
      rnd_r  <= busy ? rnd_r - 1'b1 : rnd_r;
      done_r <= (rnd_r == jad_pkg::RND_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      quo_r <= jad_pkg::DIV_QW'(req.dividend);
      dvs_r <= req.divisor;
    end else if (busy) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r[jad_pkg::SUM_W-1:0];

endmodule

`default_nettype wire

// ----- src/joystick_average_direction.sv -----
// ----------------------------------------------------------------------------
// joystick_average_direction: windowed joystick mean with dead-zone class
// Keeps the last WINDOW samples per axis in a ring memory with running sums,
// divides each sum by the sample count and classifies each mean against the
// dead zone around the configured center.
//
//   Channel   Direction  Payload
//   in_if     sink       sample_x, sample_y
//   out_if    source     mean_x, mean_y, dir_x, dir_y
//   cfg_if    sink       index (0 center_level, 1 dead_margin), data
//
// An accepted sample pair passes the READ and DIV states, and HOLD if the
// output register is still full, to the result register; the iterative
// divider retires four quotient bits per cycle.
// Reset is synchronous; ring entries not yet written read as zero through
// the fill count, so no clearing pass is needed.
// A new sample pair is accepted while the previous result waits in the
// output register; a result that finds that register full waits in HOLD.
// ----------------------------------------------------------------------------
`default_nettype none

module joystick_average_direction (
  input  wire logic  clk,
  input  wire logic  rst_n,
  jad_in_if.sink     in_if,
  jad_out_if.source  out_if,
  jad_cfg_if.sink    cfg_if
);

  jad_pkg::state_t                  state_r, state_nxt;

  logic [jad_pkg::CFG_BITS-1:0]     center_r;
  logic [jad_pkg::CFG_BITS-1:0]     margin_r;

  logic [jad_pkg::SAMPLE_BITS-1:0]  samp_x_r;
  logic [jad_pkg::SAMPLE_BITS-1:0]  samp_y_r;
  logic [jad_pkg::SUM_W-1:0]        sum_x_r, sum_x_nxt;
  logic [jad_pkg::SUM_W-1:0]        sum_y_r, sum_y_nxt;
  logic [jad_pkg::SLOT_W-1:0]       slot_r, slot_nxt;
  logic [jad_pkg::CNT_W-1:0]        fill_r, fill_nxt;
  logic                             full;

  logic                             in_ready;
  logic                             mem_re;
  logic                             mem_we;
  logic [jad_pkg::MEM_W-1:0]        mem_rdata;
  logic [jad_pkg::SAMPLE_BITS-1:0]  old_x, old_y;

  jad_pkg::div_req_t                req_x, req_y;
  jad_pkg::div_rsp_t                rsp_x, rsp_y;
  logic                             div_start;

  logic                             out_load;
  logic                             out_valid_r;
  logic [jad_pkg::OUT_BITS-1:0]     mean_x_r, mean_y_r;
  jad_pkg::dir_t                    dir_x_r, dir_y_r;

  logic                             lo_exists;
  logic [jad_pkg::CMP_W-1:0]        lo_bound, hi_bound;
  logic [jad_pkg::CMP_W-1:0]        mx_ext, my_ext;

  function automatic jad_pkg::dir_t classify(input logic [jad_pkg::CMP_W-1:0] m,
                                             input logic lo_ok,
                                             input logic [jad_pkg::CMP_W-1:0] lo,
                                             input logic [jad_pkg::CMP_W-1:0] hi);
    jad_pkg::dir_t d;
    if (lo_ok && (m < lo)) begin
      d = jad_pkg::DIR_LOW;
    end else if (m > hi) begin
      d = jad_pkg::DIR_HIGH;
    end else begin
      d = jad_pkg::DIR_CENTER;
    end
    return d;
  endfunction

  function automatic logic [jad_pkg::OUT_BITS-1:0] clip(input logic [jad_pkg::CMP_W-1:0] m);
    logic [jad_pkg::OUT_BITS-1:0] r;
    if (m > jad_pkg::CMP_W'(jad_pkg::OUT_MAX)) begin
      r = jad_pkg::OUT_MAX;
    end else begin
      r = m[jad_pkg::OUT_BITS-1:0];
    end
    return r;
  endfunction

  // Configuration registers.
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_r <= jad_pkg::CENTER_RESET;
      margin_r <= jad_pkg::MARGIN_RESET;
    end else if (cfg_if.valid) begin
      unique case (cfg_if.index)
        jad_pkg::REG_CENTER: center_r <= cfg_if.data;
        jad_pkg::REG_MARGIN: margin_r <= cfg_if.data;
        default: ;
      endcase
    end
  end

  // Ring memory: the slot under the write pointer is read on acceptance.
  jad_ring_mem u_ring (
    .clk   (clk),
    .we    (mem_we),
    .waddr (slot_r),
    .wdata ({samp_y_r, samp_x_r}),
    .re    (mem_re),
    .raddr (slot_r),
    .rdata (mem_rdata)
  );

  // While the ring is filling, the slot under the pointer was never written.
  assign full  = (fill_r == jad_pkg::CNT_W'(jad_pkg::WINDOW));
  assign old_x = full ? mem_rdata[jad_pkg::SAMPLE_BITS-1:0] : '0;
  assign old_y = full ? mem_rdata[jad_pkg::MEM_W-1:jad_pkg::SAMPLE_BITS] : '0;

  assign sum_x_nxt = sum_x_r - jad_pkg::SUM_W'(old_x) + jad_pkg::SUM_W'(samp_x_r);
  assign sum_y_nxt = sum_y_r - jad_pkg::SUM_W'(old_y) + jad_pkg::SUM_W'(samp_y_r);
  assign slot_nxt  = (slot_r == jad_pkg::SLOT_W'(jad_pkg::WINDOW - 1)) ? '0 : slot_r + 1'b1;
  assign fill_nxt  = full ? fill_r : fill_r + 1'b1;

  always_ff @(posedge clk) begin
    if (in_if.valid && in_ready) begin
      samp_x_r <= jad_pkg::SAMPLE_BITS'(in_if.sample_x);
      samp_y_r <= jad_pkg::SAMPLE_BITS'(in_if.sample_y);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_x_r <= '0;
      sum_y_r <= '0;
      slot_r  <= '0;
      fill_r  <= '0;
    end else if (mem_we) begin
      sum_x_r <= sum_x_nxt;
      sum_y_r <= sum_y_nxt;
      slot_r  <= slot_nxt;
      fill_r  <= fill_nxt;
    end
  end

  // Dividers, one per axis, started together.
  assign req_x.start    = div_start;
  assign req_x.dividend = sum_x_nxt;
  assign req_x.divisor  = fill_nxt;
  assign req_y.start    = div_start;
  assign req_y.dividend = sum_y_nxt;
  assign req_y.divisor  = fill_nxt;

  jad_divider u_div_x (.clk(clk), .rst_n(rst_n), .req(req_x), .rsp(rsp_x));
  jad_divider u_div_y (.clk(clk), .rst_n(rst_n), .req(req_y), .rsp(rsp_y));

  // Controller.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= jad_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    mem_re    = 1'b0;
    mem_we    = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      jad_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        mem_re   = in_if.valid;
        if (in_if.valid) begin
          state_nxt = jad_pkg::ST_READ;
        end
      end
      jad_pkg::ST_READ: begin
        mem_we    = 1'b1;
        div_start = 1'b1;
        state_nxt = jad_pkg::ST_DIV;
      end
      jad_pkg::ST_DIV: begin
        if (rsp_x.done) begin
          if (!out_valid_r || out_if.ready) begin
            out_load  = 1'b1;
            state_nxt = jad_pkg::ST_IDLE;
          end else begin
            state_nxt = jad_pkg::ST_HOLD;
          end
        end
      end
      jad_pkg::ST_HOLD: begin
        if (!out_valid_r || out_if.ready) begin
          out_load  = 1'b1;
          state_nxt = jad_pkg::ST_IDLE;
        end
      end
      default: state_nxt = jad_pkg::ST_IDLE;
    endcase
  end

  assign in_if.ready = in_ready;

  // Dead-zone classification and output register.
  assign lo_exists = (center_r > margin_r);
  assign lo_bound  = jad_pkg::CMP_W'(center_r) - jad_pkg::CMP_W'(margin_r);
  assign hi_bound  = jad_pkg::CMP_W'(center_r) + jad_pkg::CMP_W'(margin_r);
  assign mx_ext    = jad_pkg::CMP_W'(rsp_x.quotient);
  assign my_ext    = jad_pkg::CMP_W'(rsp_y.quotient);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      mean_x_r <= clip(mx_ext);
      mean_y_r <= clip(my_ext);
      dir_x_r  <= classify(mx_ext, lo_exists, lo_bound, hi_bound);
      dir_y_r  <= classify(my_ext, lo_exists, lo_bound, hi_bound);
    end
  end

  assign out_if.valid  = out_valid_r;
  assign out_if.mean_x = mean_x_r;
  assign out_if.mean_y = mean_y_r;
  assign out_if.dir_x  = dir_x_r;
  assign out_if.dir_y  = dir_y_r;

  a_accept_reads: assert property (@(posedge clk) disable iff (!rst_n)
    in_if.valid && in_if.ready |=> state_r == jad_pkg::ST_READ)
    else $error("Accepted transaction did not move the controller to the read state.");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= jad_pkg::CNT_W'(jad_pkg::WINDOW))
    else $error("Fill count exceeds the window length.");

  a_slot_bound: assert property (@(posedge clk) disable iff (!rst_n)
    slot_r <= jad_pkg::SLOT_W'(jad_pkg::WINDOW - 1))
    else $error("Write slot lies outside the ring.");

  a_slot_tracks_fill: assert property (@(posedge clk) disable iff (!rst_n)
    !full |-> jad_pkg::CNT_W'(slot_r) == fill_r)
    else $error("Write slot and fill count disagree while the ring is filling.");

  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    rsp_x.done |-> state_r == jad_pkg::ST_DIV && rsp_y.done)
    else $error("Divider finished outside the divide state or out of step.");

endmodule

`default_nettype wire

// ----- tb/joystick_average_direction_tb.sv -----
// ----------------------------------------------------------------------------
// joystick_average_direction_tb: self-checking testbench for the joystick
// windowed average and dead-zone classifier.
// A table of directed rows covers full-scale samples, ring wrap, a dead zone
// that reaches past the low end of the scale and writes to unused register
// indexes. Random phases with new register settings follow. Every result is
// compared with an in-bench model of the sample rings, running sums and zone
// bounds, or with the values its table row gives, while the sample sender
// works in bursts and the result receiver stalls on a changing pattern.
// ----------------------------------------------------------------------------
module joystick_average_direction_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 300000;
  localparam int NUM_ROWS    = 29;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 144;

  localparam logic [jad_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [jad_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  typedef struct packed {
    logic [jad_pkg::OUT_BITS-1:0] mean_x;
    logic [jad_pkg::OUT_BITS-1:0] mean_y;
    jad_pkg::dir_t                dir_x;
    jad_pkg::dir_t                dir_y;
  } avg_result_t;

  typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;

  typedef struct {
    row_kind_t     kind;
    logic [11:0]   arg_a;
    logic [11:0]   arg_b;
    logic          typed;
    avg_result_t   want;
  } step_row_t;

  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_LONG} rx_mode_t;

  logic clk = 1'b0;
  logic rst_n;

  jad_in_if  in_if();
  jad_out_if out_if();
  jad_cfg_if cfg_if();

  joystick_average_direction dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_if),
    .out_if(out_if),
    .cfg_if(cfg_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [jad_pkg::SAMPLE_BITS-1:0] ring_x [jad_pkg::WINDOW];
  logic [jad_pkg::SAMPLE_BITS-1:0] ring_y [jad_pkg::WINDOW];
  int                              sum_x_q;
  int                              sum_y_q;
  int                              slot_q;
  int                              fill_q;
  logic [jad_pkg::CFG_BITS-1:0]    center_q;
  logic [jad_pkg::CFG_BITS-1:0]    margin_q;

  avg_result_t want_q[$];
  logic        typed_armed = 1'b0;
  avg_result_t typed_want;
  int          fail_count = 0;
  int          cycle_count = 0;
  int          burst_left = 0;

  rx_mode_t rx_mode = RX_OPEN;
  int       rx_left = 0;
  int       rx_tick = 0;

  function automatic jad_pkg::dir_t zone_of(input int mean);
    int lo;
    int hi;
    lo = int'(center_q) - int'(margin_q);
    hi = int'(center_q) + int'(margin_q);
    if (mean < lo) return jad_pkg::DIR_LOW;
    if (mean > hi) return jad_pkg::DIR_HIGH;
    return jad_pkg::DIR_CENTER;
  endfunction

  function automatic avg_result_t advance_window(input logic [jad_pkg::IN_BITS-1:0] nx,
                                                 input logic [jad_pkg::IN_BITS-1:0] ny);
    avg_result_t r;
    int          mx;
    int          my;
    if (slot_q >= jad_pkg::WINDOW) slot_q = 0;
    sum_x_q = sum_x_q - int'(ring_x[slot_q]) + int'(nx);
    sum_y_q = sum_y_q - int'(ring_y[slot_q]) + int'(ny);
    ring_x[slot_q] = nx;
    ring_y[slot_q] = ny;
    slot_q = (slot_q + 1 >= jad_pkg::WINDOW) ? 0 : slot_q + 1;
    if (fill_q < jad_pkg::WINDOW) fill_q++;
    mx = sum_x_q / fill_q;
    my = sum_y_q / fill_q;
    r.mean_x = (mx > int'(jad_pkg::OUT_MAX)) ? jad_pkg::OUT_MAX : jad_pkg::OUT_BITS'(mx);
    r.mean_y = (my > int'(jad_pkg::OUT_MAX)) ? jad_pkg::OUT_MAX : jad_pkg::OUT_BITS'(my);
    r.dir_x  = zone_of(mx);
    r.dir_y  = zone_of(my);
    return r;
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    avg_result_t want;
    if (!rst_n) begin
      for (int i = 0; i < jad_pkg::WINDOW; i++) begin
        ring_x[i] = '0;
        ring_y[i] = '0;
      end
      sum_x_q  = 0;
      sum_y_q  = 0;
      slot_q   = 0;
      fill_q   = 0;
      center_q = jad_pkg::CENTER_RESET;
      margin_q = jad_pkg::MARGIN_RESET;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (want_q.size() == 0) begin
          $error("result with no transaction pending: mean_x %0d mean_y %0d",
                 out_if.mean_x, out_if.mean_y);
          fail_count++;
        end else begin
          want = want_q.pop_front();
          check_field("mean_x", want.mean_x, out_if.mean_x);
          check_field("mean_y", want.mean_y, out_if.mean_y);
          check_field("dir_x", want.dir_x, out_if.dir_x);
          check_field("dir_y", want.dir_y, out_if.dir_y);
        end
      end
      if (in_if.valid && in_if.ready) begin
        want = advance_window(in_if.sample_x, in_if.sample_y);
        if (typed_armed) begin
          want        = typed_want;
          typed_armed = 1'b0;
        end
        want_q.push_back(want);
      end
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_if.index)
          jad_pkg::REG_CENTER: center_q = cfg_if.data;
          jad_pkg::REG_MARGIN: margin_q = cfg_if.data;
          default: ;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_left = $urandom_range(16, 160);
    end
    rx_left--;
    rx_tick++;
    case (rx_mode)
      RX_OPEN:   out_if.ready <= 1'b1;
      RX_COIN:   out_if.ready <= ($urandom_range(0, 1) == 1);
      RX_SPARSE: out_if.ready <= (rx_tick % 4 == 0);
      default:   out_if.ready <= (rx_tick % 16 >= 11);
    endcase
  end

  task automatic pace();
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
  endtask

  task automatic send_pair(input logic [jad_pkg::IN_BITS-1:0] sx,
                           input logic [jad_pkg::IN_BITS-1:0] sy);
    in_if.valid    <= 1'b1;
    in_if.sample_x <= sx;
    in_if.sample_y <= sy;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [jad_pkg::CFG_IDX_W-1:0] idx,
                           input logic [jad_pkg::CFG_BITS-1:0] val);
    in_if.valid <= 1'b0;
    while (want_q.size() != 0) @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [jad_pkg::IN_BITS-1:0] draw_sample();
    int v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = int'(center_q) + int'($urandom_range(0, 1200)) - 600;
      4, 5, 6:    v = int'($urandom_range(0, 4095));
      7:          v = ($urandom_range(0, 1) == 1) ? 4095 : 0;
      default:    v = int'(center_q) + (($urandom_range(0, 1) == 1) ? 1 : -1) * int'(margin_q)
                      + int'($urandom_range(0, 8)) - 4;
    endcase
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return jad_pkg::IN_BITS'(v);
  endfunction

  initial begin
    step_row_t                    rows [NUM_ROWS];
    logic [jad_pkg::CFG_BITS-1:0] lvl;
    logic [jad_pkg::CFG_BITS-1:0] half;

    rst_n          = 1'b0;
    in_if.valid    = 1'b0;
    in_if.sample_x = '0;
    in_if.sample_y = '0;
    out_if.ready   = 1'b0;
    cfg_if.valid   = 1'b0;
    cfg_if.index   = '0;
    cfg_if.data    = '0;

    rows[0]  = '{ROW_SAMPLE, 12'd0, 12'd4095, 1'b1,
                 '{12'd0, 12'd4095, jad_pkg::DIR_LOW, jad_pkg::DIR_HIGH}};
    rows[1]  = '{ROW_SAMPLE, 12'd4095, 12'd0, 1'b1,
                 '{12'd2047, 12'd2047, jad_pkg::DIR_CENTER, jad_pkg::DIR_CENTER}};
    rows[2]  = '{ROW_SAMPLE, 12'd2047, 12'd2048, 1'b0, '0};
    rows[3]  = '{ROW_SAMPLE, 12'd1, 12'd4094, 1'b0, '0};
    rows[4]  = '{ROW_SAMPLE, 12'hAAA, 12'h555, 1'b0, '0};
    rows[5]  = '{ROW_SAMPLE, 12'h555, 12'hAAA, 1'b0, '0};
    rows[6]  = '{ROW_SAMPLE, 12'd4095, 12'd4095, 1'b0, '0};
    rows[7]  = '{ROW_SAMPLE, 12'd0, 12'd0, 1'b0, '0};
    rows[8]  = '{ROW_SAMPLE, 12'd1747, 12'd2347, 1'b0, '0};
    rows[9]  = '{ROW_SAMPLE, 12'd1746, 12'd2348, 1'b0, '0};
    rows[10] = '{ROW_SAMPLE, 12'd3000, 12'd1000, 1'b0, '0};
    rows[11] = '{ROW_SAMPLE, 12'd4095, 12'd0, 1'b0, '0};
    rows[12] = '{ROW_SAMPLE, 12'd0, 12'd4095, 1'b0, '0};
    rows[13] = '{ROW_WRITE, 12'(jad_pkg::REG_CENTER), 12'd0, 1'b0, '0};
    rows[14] = '{ROW_WRITE, 12'(jad_pkg::REG_MARGIN), 12'd4095, 1'b0, '0};
    rows[15] = '{ROW_SAMPLE, 12'd0, 12'd0, 1'b0, '0};
    rows[16] = '{ROW_SAMPLE, 12'd4095, 12'd4095, 1'b0, '0};
    rows[17] = '{ROW_WRITE, 12'(jad_pkg::REG_CENTER), 12'd4095, 1'b0, '0};
    rows[18] = '{ROW_WRITE, 12'(jad_pkg::REG_MARGIN), 12'd0, 1'b0, '0};
    rows[19] = '{ROW_SAMPLE, 12'd4095, 12'd4095, 1'b0, '0};
    rows[20] = '{ROW_SAMPLE, 12'd4095, 12'd4095, 1'b0, '0};
    rows[21] = '{ROW_WRITE, 12'(REG_SPARE_A), 12'h123, 1'b0, '0};
    rows[22] = '{ROW_WRITE, 12'(REG_SPARE_B), 12'hFFF, 1'b0, '0};
    rows[23] = '{ROW_SAMPLE, 12'd0, 12'd4095, 1'b0, '0};
    rows[24] = '{ROW_WRITE, 12'(jad_pkg::REG_CENTER), 12'd2047, 1'b0, '0};
    rows[25] = '{ROW_WRITE, 12'(jad_pkg::REG_MARGIN), 12'd0, 1'b0, '0};
    rows[26] = '{ROW_SAMPLE, 12'd2047, 12'd2047, 1'b0, '0};
    rows[27] = '{ROW_SAMPLE, 12'd2048, 12'd2046, 1'b0, '0};
    rows[28] = '{ROW_WRITE, 12'(jad_pkg::REG_MARGIN), 12'd300, 1'b0, '0};

    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_WRITE) begin
        write_reg(rows[i].arg_a[jad_pkg::CFG_IDX_W-1:0], rows[i].arg_b);
      end else begin
        pace();
        typed_armed = rows[i].typed;
        typed_want  = rows[i].want;
        send_pair(rows[i].arg_a, rows[i].arg_b);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      case ($urandom_range(0, 3))
        0:       lvl = 12'd0;
        1:       lvl = 12'd4095;
        default: lvl = jad_pkg::CFG_BITS'($urandom_range(0, 4095));
      endcase
      case ($urandom_range(0, 4))
        0:       half = 12'd0;
        1:       half = 12'd4095;
        2, 3:    half = jad_pkg::CFG_BITS'($urandom_range(0, 500));
        default: half = jad_pkg::CFG_BITS'($urandom_range(0, 4095));
      endcase
      write_reg(jad_pkg::REG_CENTER, lvl);
      write_reg(jad_pkg::REG_MARGIN, half);
      if ($urandom_range(0, 3) == 0) begin
        write_reg(($urandom_range(0, 1) == 1) ? REG_SPARE_A : REG_SPARE_B,
                  jad_pkg::CFG_BITS'($urandom_range(0, 4095)));
      end
      repeat (PHASE_ITEMS) begin
        pace();
        typed_armed = 1'b0;
        send_pair(draw_sample(), draw_sample());
      end
    end

    in_if.valid <= 1'b0;
    while (want_q.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
